// ===== hw/rtl/htfl_pkg.sv =====
package htfl_pkg;

    localparam int ENTRIES = 64;
    localparam int EW = $clog2(ENTRIES);

    typedef enum logic [3:0] {
        CMD_CREATE    = 4'd0,
        CMD_QUERY     = 4'd1,
        CMD_READ      = 4'd2,
        CMD_INVAL     = 4'd3,
        CMD_INVAL_ALL = 4'd4,
        CMD_KEEP_SET  = 4'd5,
        CMD_KEEP_CLR  = 4'd6,
        CMD_KEEP_CLRA = 4'd7,
        CMD_SWEEP     = 4'd8
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HEAP  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]         command;
        logic [5:0]         entry_sel;
        logic signed [31:0] in_key;
        logic [31:0]        in_handle;
        logic [15:0]        in_bytes;
        logic               heap_ok;
        logic [5:0]         random_pick;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         entry_out;
        logic               is_valid;
        logic signed [31:0] out_key;
        logic [31:0]        out_handle;
        logic [15:0]        out_bytes;
        logic               freed;
        logic [31:0]        freed_handle;
        logic [15:0]        freed_bytes;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  command;
        logic        sel_ok;
        logic [EW-1:0] sel;
        logic signed [31:0] key;
        logic [31:0] handle;
        logic [15:0] bytes;
        logic        heap_ok;
        logic [EW-1:0] pick;
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EXEC, S_SCAN, S_SCAN_RD, S_SCAN_EMIT
    } t_state;

endpackage

// ===== hw/rtl/htfl_front.sv =====
module htfl_front import htfl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_op      o_op,
    input  logic     i_take
);
    // two-entry queue of classified commands
    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, take_ok;
    t_op        op;
    logic [5:0] pk;

    always_comb begin
        pk = i_word.random_pick;
        op.command = i_word.command;
        op.sel_ok  = (i_word.entry_sel != '0) && ({1'b0, i_word.entry_sel} < 7'(ENTRIES));
        op.sel     = EW'(i_word.entry_sel);
        op.key     = i_word.in_key;
        op.handle  = i_word.in_handle;
        op.bytes   = i_word.in_bytes;
        op.heap_ok = i_word.heap_ok;
        op.pick    = ((pk != '0) && ({1'b0, pk} < 7'(ENTRIES))) ? EW'(pk) : EW'(1);
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_op    = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (take_ok) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(take_ok);
        end
    end
endmodule

// ===== hw/rtl/htfl_back.sv =====
module htfl_back import htfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_op       i_op,
    output logic      o_take,
    output logic      o_empty,
    output t_out_word o_word,
    input  logic      i_pop
);
    logic signed [31:0] r_keys [ENTRIES];
    logic [31:0]        r_hdl  [ENTRIES];
    logic [15:0]        r_sz   [ENTRIES];
    logic [EW-1:0]      r_lnk  [ENTRIES];
    logic [ENTRIES-1:0] r_vm, n_vm, r_km, n_km, r_lw, n_lw;
    logic [EW-1:0]      r_head, n_head;

    t_state    r_st, n_st;
    t_op       r_op, n_op;
    logic [EW-1:0] r_e, n_e, r_i, n_i;
    logic      r_any, n_any;
    logic      r_full, n_full;
    t_out_word r_out, n_out;

    logic [EW-1:0] rd_a;
    logic signed [31:0] rd_key;
    logic [31:0] rd_hdl;
    logic [15:0] rd_sz;
    logic [EW-1:0] rd_lnk;
    logic        we_dat, we_lnk;
    logic [EW-1:0] wa, wlnk;
    logic [ENTRIES-1:0] cand;
    logic        more;

    assign o_empty = !r_full;
    assign o_word  = r_out;

    // entries still to release in this scan, above the current one
    assign cand = r_vm & ~((r_op.command == CMD_SWEEP) ? r_km : '0);
    assign more = |((cand >> r_i) >> 1);

    always_ff @(posedge i_clk) begin
        rd_key <= r_keys[rd_a];
        rd_hdl <= r_hdl[rd_a];
        rd_sz  <= r_sz[rd_a];
        rd_lnk <= r_lnk[rd_a];
        if (we_dat) begin
            r_keys[wa] <= r_op.key;
            r_hdl[wa]  <= r_op.handle;
            r_sz[wa]   <= r_op.bytes;
        end
        if (we_lnk) r_lnk[wa] <= wlnk;
    end

    // link reads before first write give i+1 (last links to 0)
    logic [EW-1:0] r_ra;
    logic [EW-1:0] lnk_v;
    always_ff @(posedge i_clk) r_ra <= rd_a;
    assign lnk_v = r_lw[r_ra] ? rd_lnk : EW'(r_ra + EW'(1));

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_e   <= n_e;
        r_i   <= n_i;
        r_any <= n_any;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_vm   <= '0;
            r_km   <= '0;
            r_lw   <= '0;
            r_head <= EW'(1);
            r_full <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_vm   <= n_vm;
            r_km   <= n_km;
            r_lw   <= n_lw;
            r_head <= n_head;
            r_full <= n_full;
        end
    end

    always_comb begin
        n_st = r_st; n_op = r_op; n_e = r_e; n_i = r_i; n_any = r_any;
        n_vm = r_vm; n_km = r_km; n_lw = r_lw; n_head = r_head;
        n_full = r_full && !i_pop; n_out = r_out;
        o_take = 1'b0; rd_a = r_e; we_dat = 1'b0; we_lnk = 1'b0;
        wa = r_e; wlnk = '0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_op = i_op;
                    n_e  = (i_op.command == CMD_CREATE)
                         ? ((r_head != '0) ? r_head : i_op.pick) : i_op.sel;
                    rd_a = n_e;
                    n_i  = EW'(1);
                    n_any = 1'b0;
                    n_st = (i_op.command == CMD_INVAL_ALL || i_op.command == CMD_SWEEP)
                         ? S_SCAN : S_RD;
                end
            end
            S_RD: n_st = S_EXEC;
            S_EXEC: begin
                if (!n_full) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_full = 1'b1;
                    n_st = S_IDLE;
                    case (t_cmd'(r_op.command))
                        CMD_CREATE: begin
                            if (!r_op.heap_ok) n_out.status = ST_HEAP;
                            else begin
                                if (r_head != '0) n_head = lnk_v;
                                n_out.entry_out = 6'(r_e);
                                if (r_vm[r_e]) begin
                                    n_out.freed = 1'b1;
                                    n_out.freed_handle = rd_hdl;
                                    n_out.freed_bytes = rd_sz;
                                end
                                n_vm[r_e] = 1'b1; n_km[r_e] = 1'b1;
                                we_dat = 1'b1; we_lnk = 1'b1; wlnk = '0;
                                n_lw[r_e] = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            n_out.status = r_op.sel_ok ? ST_OK : ST_RANGE;
                            n_out.is_valid = r_op.sel_ok && r_vm[r_e];
                        end
                        CMD_READ: begin
                            if (r_op.sel_ok) begin
                                n_out.out_key = rd_key;
                                n_out.out_handle = rd_hdl;
                                n_out.out_bytes = rd_sz;
                            end else n_out.status = ST_RANGE;
                        end
                        CMD_INVAL: begin
                            n_out.status = r_op.sel_ok ? ST_OK : ST_RANGE;
                            if (r_op.sel_ok && r_vm[r_e]) begin
                                n_out.freed = 1'b1;
                                n_out.freed_handle = rd_hdl;
                                n_out.freed_bytes = rd_sz;
                                n_vm[r_e] = 1'b0;
                                we_lnk = 1'b1; wlnk = r_head; n_lw[r_e] = 1'b1;
                                n_head = r_e;
                            end
                        end
                        CMD_KEEP_SET, CMD_KEEP_CLR: begin
                            n_out.status = r_op.sel_ok ? ST_OK : ST_RANGE;
                            if (r_op.sel_ok)
                                n_km[r_e] = (r_op.command == CMD_KEEP_SET);
                        end
                        CMD_KEEP_CLRA: n_km = '0;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_vm[r_i] && !(r_op.command == CMD_SWEEP && r_km[r_i])) begin
                    rd_a = r_i; n_e = r_i; n_st = S_SCAN_RD;
                end else if (r_i == EW'(ENTRIES - 1)) begin
                    n_st = S_SCAN_EMIT;
                end else n_i = r_i + EW'(1);
            end
            S_SCAN_RD: n_st = S_SCAN_EMIT;
            S_SCAN_EMIT: begin
                if (!n_full) begin
                    n_out = '0;
                    n_full = 1'b1;
                    if (r_vm[r_i] && !(r_op.command == CMD_SWEEP && r_km[r_i])) begin
                        n_out.freed = 1'b1;
                        n_out.freed_handle = rd_hdl;
                        n_out.freed_bytes = rd_sz;
                        n_vm[r_i] = 1'b0;
                        wa = r_i; we_lnk = 1'b1; wlnk = r_head; n_lw[r_i] = 1'b1;
                        n_head = r_i;
                        n_any = 1'b1;
                        if (!more) begin
                            n_out.last = 1'b1; n_st = S_IDLE;
                        end else begin
                            n_i = r_i + EW'(1); n_st = S_SCAN;
                        end
                    end else if (!r_any) begin
                        n_out.last = 1'b1; n_st = S_IDLE;
                    end else begin
                        n_full = r_full && !i_pop; n_out = r_out;
                        n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/handle_table_free_list_sweep_top.sv =====
// Single-entry commands are accepted in S_IDLE, read the table in S_RD and write their word in S_EXEC,
// which waits while the output word is still held; a new command is taken only back in S_IDLE.
// Invalidate all and sweep scan the entries and give one word per released entry,
// ending at the last entry released; with none released they give a single word.
// Synchronous active-low reset clears marks, free list and queues; table data
// is undefined until written.
module handle_table_free_list_sweep_top import htfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);
    logic v, take;
    t_op  op;

    htfl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_word(i_word), .o_valid(v), .o_op(op), .i_take(take)
    );

    htfl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v), .i_op(op), .o_take(take),
        .o_empty(empty), .o_word(o_word), .i_pop(pop)
    );
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import htfl_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_word  i_word = '0;
    t_out_word o_word;

    handle_table_free_list_sweep_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_word(i_word), .empty(empty), .pop(pop), .o_word(o_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic        tbl_valid [ENTRIES];
    logic        tbl_keep  [ENTRIES];
    logic        tbl_wr    [ENTRIES];
    logic [31:0] tbl_key   [ENTRIES];
    logic [31:0] tbl_hdl   [ENTRIES];
    logic [15:0] tbl_len   [ENTRIES];
    logic [5:0]  tbl_next  [ENTRIES];
    logic [5:0]  free_top;

    t_out_word exp_words [$];
    int        n_err = 0;
    bit        rx_hold = 1'b0;
    bit        quiet = 1'b0;

    task automatic report(input string what, input t_out_word got, input t_out_word want);
        n_err++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic t_out_word blank();
        t_out_word w;
        w = '0;
        return w;
    endfunction

    function automatic bit sel_in(input logic [5:0] e);
        return e >= 1 && e < ENTRIES;
    endfunction

    task automatic free_one(input logic [5:0] e);
        t_out_word w;
        w = blank();
        w.freed = 1'b1;
        w.freed_handle = tbl_hdl[e];
        w.freed_bytes = tbl_len[e];
        tbl_valid[e] = 1'b0;
        tbl_next[e] = free_top;
        free_top = e;
        exp_words.push_back(w);
    endtask

    task automatic predict_table(input t_in_word c);
        t_out_word w;
        int        n0;
        logic [5:0] e;
        bit        ok;
        bit        lst;
        w = blank();
        n0 = exp_words.size();
        ok = sel_in(c.entry_sel);
        case (c.command)
            CMD_CREATE: begin
                lst = free_top != 0;
                e = lst ? free_top : (sel_in(c.random_pick) ? c.random_pick : 6'd1);
                if (!c.heap_ok) begin
                    w.status = ST_HEAP;
                end else begin
                    if (lst) free_top = tbl_next[e];
                    w.entry_out = e;
                    if (tbl_valid[e]) begin
                        w.freed = 1'b1;
                        w.freed_handle = tbl_hdl[e];
                        w.freed_bytes = tbl_len[e];
                    end
                    tbl_valid[e] = 1'b1;
                    tbl_keep[e] = 1'b1;
                    tbl_wr[e] = 1'b1;
                    tbl_key[e] = c.in_key;
                    tbl_hdl[e] = c.in_handle;
                    tbl_len[e] = c.in_bytes;
                    tbl_next[e] = '0;
                end
                exp_words.push_back(w);
            end
            CMD_QUERY: begin
                w.status = ok ? ST_OK : ST_RANGE;
                w.is_valid = ok && tbl_valid[c.entry_sel];
                exp_words.push_back(w);
            end
            CMD_READ: begin
                if (ok) begin
                    w.out_key = tbl_key[c.entry_sel];
                    w.out_handle = tbl_hdl[c.entry_sel];
                    w.out_bytes = tbl_len[c.entry_sel];
                end else begin
                    w.status = ST_RANGE;
                end
                exp_words.push_back(w);
            end
            CMD_INVAL: begin
                if (ok && tbl_valid[c.entry_sel]) begin
                    free_one(c.entry_sel);
                end else begin
                    w.status = ok ? ST_OK : ST_RANGE;
                    exp_words.push_back(w);
                end
            end
            CMD_INVAL_ALL, CMD_SWEEP: begin
                for (int i = 1; i < ENTRIES; i++)
                    if (tbl_valid[i] && !(c.command == CMD_SWEEP && tbl_keep[i]))
                        free_one(i[5:0]);
                if (exp_words.size() == n0) exp_words.push_back(w);
            end
            CMD_KEEP_SET, CMD_KEEP_CLR: begin
                if (ok) tbl_keep[c.entry_sel] = c.command == CMD_KEEP_SET;
                w.status = ok ? ST_OK : ST_RANGE;
                exp_words.push_back(w);
            end
            CMD_KEEP_CLRA: begin
                for (int i = 0; i < ENTRIES; i++) tbl_keep[i] = 1'b0;
                exp_words.push_back(w);
            end
            default: exp_words.push_back(w);
        endcase
        w = exp_words[$];
        w.last = 1'b1;
        exp_words[$] = w;
    endtask

    function automatic t_in_word mk(input t_cmd c, input logic [5:0] sel,
                                    input logic [31:0] k, input logic [31:0] h,
                                    input logic [15:0] b, input logic ok,
                                    input logic [5:0] pk);
        t_in_word w;
        w.command = c;
        w.entry_sel = sel;
        w.in_key = k;
        w.in_handle = h;
        w.in_bytes = b;
        w.heap_ok = ok;
        w.random_pick = pk;
        return w;
    endfunction

    // avoid reading never-written entries
    function automatic t_in_word fix_read(input t_in_word c);
        if (c.command == CMD_READ && sel_in(c.entry_sel) && !tbl_wr[c.entry_sel])
            c.command = CMD_QUERY;
        return c;
    endfunction

    function automatic t_in_word rnd_word();
        t_in_word c;
        int r;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(t_in_word)-1:0];
        r = $urandom_range(0, 99);
        if (r < 40) c.command = CMD_CREATE;
        else if (r < 47) c.command = CMD_SWEEP;
        else if (r < 50) c.command = CMD_INVAL_ALL;
        else if (r < 53) c.command = t_cmd'($urandom_range(9, 15));
        else c.command = t_cmd'($urandom_range(1, 7));
        c.heap_ok = $urandom_range(0, 9) != 0;
        return fix_read(c);
    endfunction

    task automatic send(input t_in_word c, input bit chk, input t_out_word want);
        t_out_word w;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        c = fix_read(c);
        push <= 1'b1;
        i_word <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_table(c);
        if (chk) begin
            w = exp_words[$];
            if (w !== want) report("directed", w, want);
        end
        @(negedge i_clk);
    endtask

    t_in_word  dir_tbl [$];
    t_out_word dir_exp [$];
    bit        dir_chk [$];

    task automatic row(input t_in_word c, input bit chk, input t_out_word want);
        dir_tbl.push_back(c);
        dir_chk.push_back(chk);
        dir_exp.push_back(want);
    endtask

    initial begin
        t_out_word w;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 0; tbl_keep[i] = 0; tbl_wr[i] = 0;
            tbl_key[i] = 0; tbl_hdl[i] = 0; tbl_len[i] = 0;
            tbl_next[i] = 6'((i + 1 < ENTRIES) ? i + 1 : 0);
        end
        free_top = 1;
        w = blank(); w.status = ST_RANGE; w.last = 1;
        row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(CMD_READ, 63, 0, 0, 0, 0, 0), 0, w);
        w = blank(); w.status = ST_HEAP; w.last = 1;
        row(mk(CMD_CREATE, 0, 0, 0, 0, 0, 0), 1, w);
        w = blank(); w.entry_out = 1; w.last = 1;
        row(mk(CMD_CREATE, 0, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1, 0), 1, w);
        row(mk(CMD_CREATE, 0, 32'h7FFF_FFFF, 0, 0, 1, 0), 0, w);
        row(mk(CMD_READ, 1, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_QUERY, 2, 0, 0, 0, 0, 0), 0, w);
        w = blank(); w.status = ST_RANGE; w.last = 1;
        row(mk(CMD_INVAL, 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(CMD_KEEP_SET, 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(CMD_KEEP_CLR, 63, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_KEEP_CLR, 1, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_INVAL, 2, 0, 0, 0, 0, 0), 0, w);
        w = blank(); w.last = 1;
        row(mk(CMD_INVAL, 5, 0, 0, 0, 0, 0), 1, w);
        row(mk(CMD_KEEP_CLRA, 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(t_cmd'(4'd15), 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(t_cmd'(4'd9), 0, 0, 0, 0, 0, 0), 1, w);
        row(mk(CMD_INVAL_ALL, 0, 0, 0, 0, 0, 0), 1, w);
        // fill the table, then overwrite by random pick (0 maps to 1, 63 is taken as is)
        for (int i = 0; i < 63; i++)
            row(mk(CMD_CREATE, 0, $urandom, $urandom, 16'($urandom), 1, 0), 0, w);
        row(mk(CMD_CREATE, 0, 1, 2, 3, 1, 0), 0, w);
        row(mk(CMD_CREATE, 0, 4, 5, 6, 1, 63), 0, w);
        row(mk(CMD_CREATE, 0, 4, 5, 6, 0, 17), 0, w);
        row(mk(CMD_KEEP_CLR, 3, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0), 0, w);
        row(mk(CMD_INVAL_ALL, 0, 0, 0, 0, 0, 0), 0, w);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tbl[i]) send(dir_tbl[i], dir_chk[i], dir_exp[i]);
        for (int i = 0; i < 64; i++) begin
            if (i == 20) rx_hold = 1'b1;
            if (i == 40) rx_hold = 1'b0;
            if (i == 50) quiet = 1'b1;
            send(rnd_word(), 0, w);
        end
        push <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // receiver
    initial begin
        t_out_word want;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                pop <= 1'b0;
                repeat (300) @(negedge i_clk);
                rx_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                pop <= 1'b1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (exp_words.size() == 0) begin
                report("unexpected", o_word, blank());
            end else if (o_word !== exp_words[0]) begin
                report("result", o_word, exp_words[0]);
                void'(exp_words.pop_front());
            end else begin
                void'(exp_words.pop_front());
            end
        end
    end

    initial begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/htfl_pkg.sv
hw/rtl/htfl_front.sv
hw/rtl/htfl_back.sv
hw/rtl/handle_table_free_list_sweep_top.sv
dv/tb_top.sv
